// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the receive window; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/rrw_pkg.sv
// Package of the reorder receive window: constants, codes and shared types.
package rrw_pkg;

    localparam int MAX_WINDOW_DEF    = 16;
    localparam int SEGMENT_BYTES_DEF = 512;
    localparam int TAG_BITS_DEF      = 16;

    localparam int SEQ_W     = 31;
    localparam int LEN_W     = 10;
    localparam int WS_W      = 5;
    localparam int CFG_ADR_W = 1;
    localparam int CFG_DAT_W = 31;

    localparam logic [CFG_ADR_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_ADR_W-1:0] CFG_START_SEQ   = 1'b1;

    localparam logic [WS_W-1:0]  WINDOW_SIZE_RST = 5'd16;
    localparam logic [SEQ_W-1:0] START_SEQ_RST   = 31'd1;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DIV,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_ACK
    } rrw_state_t;

    typedef struct packed {
        logic clear_all;
        logic wr_en;
        logic rd_en;
        logic inval_en;
    } rrw_mem_ctl_t;

endpackage

// File: rtl/core/reorder_receive_window_top.sv
// Top level of the reorder receive window: sequencer, shared adder and result register.
// Each accepted segment word is placed by its sequence number into a window of slots.
// A segment at the expected number lands in the base slot and starts a drain that
// delivers contiguous occupied slots in order; a segment ahead by offset/SEGMENT_BYTES
// slots inside the window is parked; anything else is dropped. Every segment ends
// with one cumulative ack word, and all words of one segment carry the final ack number.
// seg_ready is high only in idle, so a new segment is accepted only after the last one
// has been fully handled, including its ack word. The sequencer is built around the single
// shared 31-bit adder (distance, offset division by repeated subtraction, length sum) and
// the one registered read port of the slot memory. A write to either configuration
// register clears every slot and resets the window base.
`include "assert_macros.svh"

module reorder_receive_window_top #(
    parameter int MAX_WINDOW    = rrw_pkg::MAX_WINDOW_DEF,
    parameter int SEGMENT_BYTES = rrw_pkg::SEGMENT_BYTES_DEF,
    parameter int TAG_BITS      = rrw_pkg::TAG_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [rrw_pkg::CFG_ADR_W-1:0] cfg_addr,
    input  logic [rrw_pkg::CFG_DAT_W-1:0] cfg_wdata,
    // segment channel
    input  logic                          seg_valid,
    output logic                          seg_ready,
    input  logic [rrw_pkg::SEQ_W-1:0]     seq_num,
    input  logic [rrw_pkg::LEN_W-1:0]     data_len,
    input  logic                          last_seg,
    input  logic [TAG_BITS-1:0]           buffer_tag,
    // result channel
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          kind,
    output logic [rrw_pkg::SEQ_W-1:0]     out_seq,
    output logic [rrw_pkg::LEN_W-1:0]     out_len,
    output logic [TAG_BITS-1:0]           out_tag,
    output logic                          out_last,
    output logic [rrw_pkg::SEQ_W-1:0]     ack_num,
    output logic                          end_of_run
);

    localparam int SEQ_W = rrw_pkg::SEQ_W;
    localparam int LEN_W = rrw_pkg::LEN_W;
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int W_W   = $clog2(MAX_WINDOW + 1);
    localparam logic [SEQ_W-1:0] SEG_BYTES = SEQ_W'(SEGMENT_BYTES);

    rrw_pkg::rrw_state_t state_reg, state_next;

    // window and transfer state
    logic [rrw_pkg::WS_W-1:0] ws_reg;
    logic [SEQ_W-1:0]         expected_reg;
    logic [IDX_W-1:0]         base_reg;
    logic [W_W-1:0]           w_eff;

    // latched segment word
    logic [SEQ_W-1:0]    sg_seq_reg;
    logic [LEN_W-1:0]    sg_len_reg;
    logic                sg_last_reg;
    logic [TAG_BITS-1:0] sg_tag_reg;

    // sequencer working registers
    logic [SEQ_W-1:0] rem_reg;
    logic [SEQ_W-1:0] acc_reg;
    logic [W_W-1:0]   off_reg;
    logic [W_W-1:0]   cnt_reg;
    logic [W_W-1:0]   n_reg;
    logic [W_W-1:0]   ecnt_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_inc;
    logic [W_W-1:0]   ptr_p1;
    logic [W_W:0]     park_sum;
    logic [W_W:0]     park_wrap;
    logic [IDX_W-1:0] park_idx;

    // result register
    logic                res_valid_reg;
    logic                kind_reg;
    logic [SEQ_W-1:0]    oseq_reg;
    logic [LEN_W-1:0]    olen_reg;
    logic [TAG_BITS-1:0] otag_reg;
    logic                olast_reg;
    logic [SEQ_W-1:0]    ack_reg;
    logic                eor_reg;
    logic                out_free;

    // shared adder
    logic [SEQ_W-1:0] alu_a;
    logic [SEQ_W-1:0] alu_b;
    logic             alu_sub;
    logic [SEQ_W:0]   alu_sum;
    logic [SEQ_W-1:0] alu_res;
    logic             alu_carry;

    // slot memory interface
    rrw_pkg::rrw_mem_ctl_t mem_ctl;
    logic [IDX_W-1:0]      wr_idx;
    logic                  rd_valid;
    logic [SEQ_W-1:0]      rd_seq;
    logic [LEN_W-1:0]      rd_len;
    logic                  rd_last;
    logic [TAG_BITS-1:0]   rd_tag;

    logic load_dlv;
    logic load_ack;
    logic scan_done;
    logic park_hit;
    logic div_out;

    // Clamp the configured window size to 1..MAX_WINDOW.
    always_comb
    begin
        if (ws_reg == '0)
        begin
            w_eff = W_W'(1);
        end
        else if (int'(ws_reg) > MAX_WINDOW)
        begin
            w_eff = W_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = W_W'(ws_reg);
        end
    end

    // One adder serves distance, offset division and length accumulation.
    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (SEQ_W + 1)'(alu_sub);
    assign alu_res   = alu_sum[SEQ_W-1:0];
    assign alu_carry = alu_sum[SEQ_W];

    // Advance a slot pointer modulo the window.
    assign ptr_p1  = W_W'(ptr_reg) + W_W'(1);
    assign ptr_inc = (ptr_p1 == w_eff) ? '0 : IDX_W'(ptr_p1);

    // Parking slot: base plus offset, folded once into the window.
    assign park_sum  = {1'b0, W_W'(base_reg)} + {1'b0, off_reg};
    assign park_wrap = (park_sum >= {1'b0, w_eff}) ? (park_sum - {1'b0, w_eff}) : park_sum;
    assign park_idx  = IDX_W'(park_wrap);

    assign out_free  = !res_valid_reg || res_ready;
    assign scan_done = (cnt_reg == w_eff) || !rd_valid;
    // Remainder below one segment: the offset is final and already inside the window.
    assign park_hit  = !alu_carry;
    // One more subtraction would push the offset to the window size.
    assign div_out   = alu_carry && ((off_reg + W_W'(1)) == w_eff);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrw_pkg::ST_IDLE:
            begin
                if (seg_valid)
                begin
                    state_next = rrw_pkg::ST_DIFF;
                end
            end
            rrw_pkg::ST_DIFF:
            begin
                state_next = (alu_res == '0) ? rrw_pkg::ST_SCAN_RD : rrw_pkg::ST_DIV;
            end
            rrw_pkg::ST_DIV:
            begin
                if (park_hit || div_out)
                begin
                    state_next = rrw_pkg::ST_ACK;
                end
            end
            rrw_pkg::ST_SCAN_RD:
            begin
                state_next = scan_done ? rrw_pkg::ST_EMIT_RD : rrw_pkg::ST_SCAN_ACC;
            end
            rrw_pkg::ST_SCAN_ACC:
            begin
                state_next = rrw_pkg::ST_SCAN_RD;
            end
            rrw_pkg::ST_EMIT_RD:
            begin
                state_next = (ecnt_reg == n_reg) ? rrw_pkg::ST_ACK : rrw_pkg::ST_EMIT_OUT;
            end
            rrw_pkg::ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = rrw_pkg::ST_EMIT_RD;
                end
            end
            rrw_pkg::ST_ACK:
            begin
                if (out_free)
                begin
                    state_next = rrw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        seg_ready         = 1'b0;
        mem_ctl.clear_all = cfg_we;
        mem_ctl.wr_en     = 1'b0;
        mem_ctl.rd_en     = 1'b0;
        mem_ctl.inval_en  = 1'b0;
        wr_idx            = base_reg;
        alu_a             = acc_reg;
        alu_b             = SEQ_W'(sg_len_reg);
        alu_sub           = 1'b0;
        load_dlv          = 1'b0;
        load_ack          = 1'b0;
        case (state_reg)
            rrw_pkg::ST_IDLE:
            begin
                seg_ready = 1'b1;
            end
            rrw_pkg::ST_DIFF:
            begin
                alu_a         = sg_seq_reg;
                alu_b         = expected_reg;
                alu_sub       = 1'b1;
                mem_ctl.wr_en = (alu_res == '0);
                wr_idx        = base_reg;
            end
            rrw_pkg::ST_DIV:
            begin
                alu_a         = rem_reg;
                alu_b         = SEG_BYTES;
                alu_sub       = 1'b1;
                mem_ctl.wr_en = park_hit;
                wr_idx        = park_idx;
            end
            rrw_pkg::ST_SCAN_RD:
            begin
                mem_ctl.rd_en = !scan_done;
            end
            rrw_pkg::ST_SCAN_ACC:
            begin
                alu_a = acc_reg;
                alu_b = SEQ_W'(rd_len);
            end
            rrw_pkg::ST_EMIT_RD:
            begin
                mem_ctl.rd_en = (ecnt_reg != n_reg);
            end
            rrw_pkg::ST_EMIT_OUT:
            begin
                load_dlv         = out_free;
                mem_ctl.inval_en = out_free;
            end
            rrw_pkg::ST_ACK:
            begin
                load_ack = out_free;
            end
            default:
            begin
                seg_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Window state, configuration and sequencer working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg       <= rrw_pkg::WINDOW_SIZE_RST;
            expected_reg <= rrw_pkg::START_SEQ_RST;
            base_reg     <= '0;
            ptr_reg      <= '0;
            off_reg      <= '0;
            cnt_reg      <= '0;
            n_reg        <= '0;
            ecnt_reg     <= '0;
        end
        else if (cfg_we)
        begin
            // Start a new transfer: empty window, base back to slot zero.
            base_reg <= '0;
            if (cfg_addr == rrw_pkg::CFG_WINDOW_SIZE)
            begin
                ws_reg <= cfg_wdata[rrw_pkg::WS_W-1:0];
            end
            else
            begin
                expected_reg <= cfg_wdata[SEQ_W-1:0];
            end
        end
        else
        begin
            case (state_reg)
                rrw_pkg::ST_DIFF:
                begin
                    ptr_reg <= base_reg;
                    cnt_reg <= '0;
                    off_reg <= '0;
                end
                rrw_pkg::ST_DIV:
                begin
                    if (alu_carry)
                    begin
                        off_reg <= off_reg + W_W'(1);
                    end
                end
                rrw_pkg::ST_SCAN_RD:
                begin
                    if (scan_done)
                    begin
                        // Commit the drain: new expected number and base,
                        // then walk again from the old base to deliver.
                        expected_reg <= acc_reg;
                        n_reg        <= cnt_reg;
                        base_reg     <= ptr_reg;
                        ptr_reg      <= base_reg;
                        ecnt_reg     <= '0;
                    end
                end
                rrw_pkg::ST_SCAN_ACC:
                begin
                    cnt_reg <= cnt_reg + W_W'(1);
                    ptr_reg <= ptr_inc;
                end
                rrw_pkg::ST_EMIT_OUT:
                begin
                    if (out_free)
                    begin
                        ecnt_reg <= ecnt_reg + W_W'(1);
                        ptr_reg  <= ptr_inc;
                    end
                end
                default:
                begin
                    ptr_reg <= ptr_reg;
                end
            endcase
        end
    end

    // Payload-side registers: latched segment, remainder and length sum.
    always_ff @(posedge clk)
    begin
        if (seg_valid && seg_ready)
        begin
            sg_seq_reg  <= seq_num;
            sg_len_reg  <= data_len;
            sg_last_reg <= last_seg;
            sg_tag_reg  <= buffer_tag;
        end
        if (state_reg == rrw_pkg::ST_DIFF)
        begin
            rem_reg <= alu_res;
            acc_reg <= expected_reg;
        end
        if (state_reg == rrw_pkg::ST_DIV)
        begin
            rem_reg <= alu_res;
        end
        if (state_reg == rrw_pkg::ST_SCAN_ACC)
        begin
            acc_reg <= alu_res;
        end
    end

    // Result register: hold until taken, load when free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load_dlv || load_ack)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_dlv)
        begin
            kind_reg  <= rrw_pkg::KIND_DELIVER;
            oseq_reg  <= rd_seq;
            olen_reg  <= rd_len;
            otag_reg  <= rd_tag;
            olast_reg <= rd_last;
            ack_reg   <= expected_reg;
            eor_reg   <= 1'b0;
        end
        else if (load_ack)
        begin
            kind_reg  <= rrw_pkg::KIND_ACK;
            oseq_reg  <= '0;
            olen_reg  <= '0;
            otag_reg  <= '0;
            olast_reg <= 1'b0;
            ack_reg   <= expected_reg;
            eor_reg   <= 1'b1;
        end
    end

    rrw_slot_mem #(
        .DEPTH    (MAX_WINDOW),
        .IDX_W    (IDX_W),
        .TAG_BITS (TAG_BITS)
    ) u_slot_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .wr_idx   (wr_idx),
        .wr_seq   (sg_seq_reg),
        .wr_len   (sg_len_reg),
        .wr_last  (sg_last_reg),
        .wr_tag   (sg_tag_reg),
        .rd_idx   (ptr_reg),
        .rd_valid (rd_valid),
        .rd_seq   (rd_seq),
        .rd_len   (rd_len),
        .rd_last  (rd_last),
        .rd_tag   (rd_tag)
    );

    assign res_valid  = res_valid_reg;
    assign kind       = kind_reg;
    assign out_seq    = oseq_reg;
    assign out_len    = olen_reg;
    assign out_tag    = otag_reg;
    assign out_last   = olast_reg;
    assign ack_num    = ack_reg;
    assign end_of_run = eor_reg;

    // The window base always names a slot inside the window.
    `ASSERT_SAME(a_base_in_window, clk, rst_n, 1'b1, (W_W'(base_reg) < w_eff))
    // The offset division stops before the offset reaches the window size.
    `ASSERT_SAME(a_off_in_window, clk, rst_n, (state_reg == rrw_pkg::ST_DIV),
                 (off_reg < w_eff))
    // Delivery never runs past the number of slots found by the scan.
    `ASSERT_SAME(a_emit_bound, clk, rst_n,
                 (state_reg == rrw_pkg::ST_EMIT_RD || state_reg == rrw_pkg::ST_EMIT_OUT),
                 (ecnt_reg <= n_reg && n_reg <= w_eff))
    // A drain step only proceeds over an occupied slot.
    `ASSERT_NEXT(a_scan_valid, clk, rst_n,
                 (state_reg == rrw_pkg::ST_SCAN_RD && !scan_done && !cfg_we),
                 (state_reg == rrw_pkg::ST_SCAN_ACC))

endmodule

// File: rtl/core/rrw_slot_mem.sv
// Slot store of the receive window: valid flops plus a payload memory with registered read.
module rrw_slot_mem #(
    parameter int DEPTH    = rrw_pkg::MAX_WINDOW_DEF,
    parameter int IDX_W    = 4,
    parameter int TAG_BITS = rrw_pkg::TAG_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rrw_pkg::rrw_mem_ctl_t     ctl,
    input  logic [IDX_W-1:0]          wr_idx,
    input  logic [rrw_pkg::SEQ_W-1:0] wr_seq,
    input  logic [rrw_pkg::LEN_W-1:0] wr_len,
    input  logic                      wr_last,
    input  logic [TAG_BITS-1:0]       wr_tag,
    input  logic [IDX_W-1:0]          rd_idx,
    output logic                      rd_valid,
    output logic [rrw_pkg::SEQ_W-1:0] rd_seq,
    output logic [rrw_pkg::LEN_W-1:0] rd_len,
    output logic                      rd_last,
    output logic [TAG_BITS-1:0]       rd_tag
);

    localparam int ENT_W = rrw_pkg::SEQ_W + rrw_pkg::LEN_W + 1 + TAG_BITS;

    logic [DEPTH-1:0] valid_reg;
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rdata_reg;

    // Valid bits: clear all on a new transfer, set on store, drop on delivery.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clear_all)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (ctl.inval_en)
            begin
                valid_reg[rd_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_idx] <= {wr_seq, wr_len, wr_last, wr_tag};
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_idx];
        end
    end

    assign rd_valid = valid_reg[rd_idx];
    assign {rd_seq, rd_len, rd_last, rd_tag} = rdata_reg;

endmodule
